// ===== design/dpt_pkg.sv =====
`default_nettype none
package dpt_pkg;

  localparam int PAGES       = 64;
  localparam int PAGE_W      = 6;
  localparam int FRAMES      = 64;
  localparam int FRAME_W     = 6;
  localparam int QCNT_W      = 7;
  localparam int OFF_W       = 10;
  localparam int ADDR_W      = 16;
  localparam int PBYTES_W    = 17;
  localparam int PCNT_W      = 7;
  localparam int SWAP_BLOCKS = 128;
  localparam int SWAP_W      = 7;
  localparam int STAMP_BITS  = 32;

  typedef enum logic [2:0] {
    ST_HIT          = 3'd0,
    ST_REPLACED     = 3'd1,
    ST_ADDR_RANGE   = 3'd2,
    ST_PAGE_RANGE   = 3'd3,
    ST_NO_FRAMES    = 3'd4,
    ST_REPLACE_FAIL = 3'd5,
    ST_MAPPED       = 3'd6,
    ST_QUEUE_FULL   = 3'd7
  } status_t;

  typedef enum logic {
    OP_MAP    = 1'b0,
    OP_ACCESS = 1'b1
  } opcode_t;

  typedef enum logic {
    CFG_PROCESS_BYTES = 1'b0,
    CFG_USE_LRU       = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_HIT,
    S_POP,
    S_SCAN,
    S_LRU_END,
    S_REPLACE
  } state_t;

  typedef struct packed {
    logic                opcode;
    logic [PAGE_W-1:0]   map_page;
    logic [FRAME_W-1:0]  map_frame;
    logic [ADDR_W-1:0]   vaddr;
    logic                is_write;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   paddr;
    logic [PAGE_W-1:0]   page_idx;
    logic [OFF_W-1:0]    page_offset;
    logic [FRAME_W-1:0]  evict_frame;
    logic                writeback;
    logic [SWAP_W-1:0]   swap_slot;
  } out_item_t;

  typedef struct packed {
    logic    latch;
    logic    do_map;
    logic    hit_rd;
    logic    hit_commit;
    logic    pop;
    logic    scan_start;
    logic    scan_issue;
    logic    scan_cmp;
    logic    replace;
    logic    res_load;
    status_t res_status;
  } dpt_cmd_t;

  typedef struct packed {
    logic is_access;
    logic map_page_bad;
    logic addr_bad;
    logic page_bad;
    logic page_valid;
    logic has_frames;
    logic q_full;
    logic q_empty;
    logic use_lru;
    logic scan_more;
    logic match_now;
    logic last_cmp;
    logic found;
  } dpt_stat_t;

endpackage
`default_nettype wire

// ===== design/dpt_ctrl.sv =====
`default_nettype none
module dpt_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  dpt_pkg::dpt_stat_t stat,
  output dpt_pkg::dpt_cmd_t  cmd
);
  import dpt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_status = ST_HIT;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.is_access) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
          priority if (stat.map_page_bad) begin
            cmd.res_status = ST_PAGE_RANGE;
          end else if (stat.q_full) begin
            cmd.res_status = ST_QUEUE_FULL;
          end else begin
            cmd.do_map     = 1'b1;
            cmd.res_status = ST_MAPPED;
          end
        end else begin
          priority if (stat.addr_bad) begin
            cmd.res_load = 1'b1; cmd.res_status = ST_ADDR_RANGE; state_next = S_IDLE;
          end else if (stat.page_bad) begin
            cmd.res_load = 1'b1; cmd.res_status = ST_PAGE_RANGE; state_next = S_IDLE;
          end else if (stat.page_valid) begin
            cmd.hit_rd = 1'b1;
            state_next = S_HIT;
          end else if (!stat.has_frames) begin
            cmd.res_load = 1'b1; cmd.res_status = ST_NO_FRAMES; state_next = S_IDLE;
          end else if (stat.use_lru) begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end else begin
            state_next = S_POP;
          end
        end
      end
      S_HIT: begin
        cmd.hit_commit = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_HIT;
        state_next     = S_IDLE;
      end
      S_POP: begin
        if (stat.q_empty) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_REPLACE_FAIL;
          state_next     = S_IDLE;
        end else begin
          cmd.pop        = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_cmp   = 1'b1;
        cmd.scan_issue = stat.scan_more;
        if (stat.use_lru) begin
          if (stat.last_cmp) begin
            state_next = S_LRU_END;
          end
        end else begin
          priority if (stat.match_now) begin
            state_next = S_REPLACE;
          end else if (stat.last_cmp) begin
            state_next = S_POP;
          end
        end
      end
      S_LRU_END: begin
        if (stat.found) begin
          state_next = S_REPLACE;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_REPLACE_FAIL;
          state_next     = S_IDLE;
        end
      end
      S_REPLACE: begin
        cmd.replace    = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_REPLACED;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/dpt_datapath.sv =====
`default_nettype none
module dpt_datapath (
  input  wire                    clk,
  input  wire                    rst,
  input  dpt_pkg::in_item_t      in_item,
  input  wire                    cfg_we,
  input  dpt_pkg::cfg_idx_t      cfg_index,
  input  wire [16:0]             cfg_data,
  input  dpt_pkg::dpt_cmd_t      cmd,
  output dpt_pkg::dpt_stat_t     stat,
  output logic                   done,
  output dpt_pkg::out_item_t     result
);
  import dpt_pkg::*;

  logic [PBYTES_W-1:0]   process_bytes;
  logic                  use_lru;
  in_item_t              item_q;

  logic [FRAME_W-1:0]    frame_mem [PAGES];
  logic [STAMP_BITS-1:0] stamp_mem [PAGES];
  logic [FRAME_W-1:0]    fifo_mem  [FRAMES];
  logic [FRAME_W-1:0]    frame_rd;
  logic [STAMP_BITS-1:0] stamp_rd;
  logic [FRAME_W-1:0]    fifo_rd;

  logic [PAGES-1:0]      valid;
  logic [PAGES-1:0]      dirty;
  logic [PAGES-1:0]      valid_next;
  logic [PAGES-1:0]      dirty_next;
  logic [FRAME_W-1:0]    q_head;
  logic [QCNT_W-1:0]     q_count;
  logic                  has_frames;
  logic [SWAP_W:0]       swap_cnt;
  logic [STAMP_BITS-1:0] time_now;

  logic [PCNT_W-1:0]     scan_idx;
  logic [PAGE_W-1:0]     idx_d;
  logic                  cmp_vld;
  logic                  found;
  logic [STAMP_BITS-1:0] best_stamp;
  logic [PAGE_W-1:0]     vic_page;
  logic [FRAME_W-1:0]    vic_frame;

  logic [PBYTES_W:0]     pb_round;
  logic [PCNT_W:0]       pc_raw;
  logic [PCNT_W-1:0]     pc;
  logic [PAGE_W-1:0]     pnum;
  logic [OFF_W-1:0]      poff;
  logic                  cmp_ok;
  logic                  lru_better;
  logic                  mem_we;
  logic [PAGE_W-1:0]     mem_wa;
  logic [FRAME_W-1:0]    mem_wf;
  logic                  push;
  logic [FRAME_W-1:0]    push_frame;
  logic                  wb;
  logic [PAGE_W-1:0]     rd_addr;

  // page count: ceil(bytes / page size), capped
  assign pb_round = {1'b0, process_bytes} + (PBYTES_W+1)'(2**OFF_W - 1);
  assign pc_raw   = pb_round[PBYTES_W:OFF_W];
  assign pc       = (pc_raw > (PCNT_W+1)'(PAGES)) ? PCNT_W'(PAGES) : pc_raw[PCNT_W-1:0];

  assign pnum = item_q.vaddr[ADDR_W-1:OFF_W];
  assign poff = item_q.vaddr[OFF_W-1:0];

  assign cmp_ok     = cmd.scan_cmp && cmp_vld && valid[idx_d];
  assign lru_better = !found || (stamp_rd < best_stamp);

  assign stat.is_access    = (item_q.opcode == OP_ACCESS);
  assign stat.map_page_bad = ({1'b0, item_q.map_page} >= pc);
  assign stat.addr_bad     = ({1'b0, item_q.vaddr} >= process_bytes);
  assign stat.page_bad     = ({1'b0, pnum} >= pc);
  assign stat.page_valid   = valid[pnum];
  assign stat.has_frames   = has_frames;
  assign stat.q_full       = q_count[QCNT_W-1];
  assign stat.q_empty      = (q_count == '0);
  assign stat.use_lru      = use_lru;
  assign stat.scan_more    = (scan_idx < pc);
  assign stat.match_now    = cmp_ok && !use_lru && (frame_rd == fifo_rd);
  assign stat.last_cmp     = cmd.scan_cmp && cmp_vld && (({1'b0, idx_d} + PCNT_W'(1)) == pc);
  assign stat.found        = found;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_bytes <= PBYTES_W'(65536);
      use_lru       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROCESS_BYTES: process_bytes <= cfg_data;
        CFG_USE_LRU:       use_lru       <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_q <= in_item;
    end
  end

  // page table memories: one write, one read port each
  assign mem_we = cmd.do_map || cmd.replace || cmd.hit_commit;
  assign mem_wa = cmd.do_map ? item_q.map_page : pnum;
  assign mem_wf = cmd.do_map ? item_q.map_frame : vic_frame;
  assign rd_addr = cmd.hit_rd ? pnum : scan_idx[PAGE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.do_map || cmd.replace) begin
      frame_mem[mem_wa] <= mem_wf;
    end
    if (mem_we) begin
      stamp_mem[mem_wa] <= time_now;
    end
    frame_rd <= frame_mem[rd_addr];
    stamp_rd <= stamp_mem[rd_addr];
  end

  // frame queue as a ring
  assign push       = (cmd.do_map || cmd.replace) && !q_count[QCNT_W-1];
  assign push_frame = cmd.do_map ? item_q.map_frame : vic_frame;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[q_head + q_count[FRAME_W-1:0]] <= push_frame;
    end
    if (cmd.pop) begin
      fifo_rd <= fifo_mem[q_head];
    end
  end

  assign wb = dirty[vic_page] && !swap_cnt[SWAP_W];

  always_comb begin
    valid_next = valid;
    dirty_next = dirty;
    if (cmd.do_map) begin
      valid_next[item_q.map_page] = 1'b1;
      dirty_next[item_q.map_page] = 1'b0;
    end
    if (cmd.hit_commit && item_q.is_write) begin
      dirty_next[pnum] = 1'b1;
    end
    if (cmd.replace) begin
      valid_next[vic_page] = 1'b0;
      dirty_next[vic_page] = 1'b0;
      valid_next[pnum]     = 1'b1;
      dirty_next[pnum]     = item_q.is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      dirty      <= '0;
      q_head     <= '0;
      q_count    <= '0;
      has_frames <= 1'b0;
      swap_cnt   <= '0;
      time_now   <= '0;
    end else begin
      valid <= valid_next;
      dirty <= dirty_next;
      if (cmd.pop) begin
        q_head  <= q_head + FRAME_W'(1);
        q_count <= q_count - QCNT_W'(1);
      end else if (push) begin
        q_count <= q_count + QCNT_W'(1);
      end
      if (cmd.do_map) begin
        has_frames <= 1'b1;
      end
      if (cmd.replace && wb) begin
        swap_cnt <= swap_cnt + (SWAP_W+1)'(1);
      end
      if ((cmd.hit_commit || cmd.replace) && (time_now != '1)) begin
        time_now <= time_now + STAMP_BITS'(1);
      end
    end
  end

  // scan engine: read issued one cycle, compared the next
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
      found   <= 1'b0;
    end else if (cmd.scan_start) begin
      cmp_vld <= 1'b0;
      found   <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_issue;
      if (cmp_ok && (use_lru ? lru_better : (frame_rd == fifo_rd))) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_issue) begin
      scan_idx <= scan_idx + PCNT_W'(1);
      idx_d    <= scan_idx[PAGE_W-1:0];
    end
    if (cmp_ok && (use_lru ? lru_better : (frame_rd == fifo_rd))) begin
      best_stamp <= stamp_rd;
      vic_page   <= idx_d;
      vic_frame  <= frame_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result.status <= cmd.res_status;
      if (item_q.opcode == OP_ACCESS) begin
        result.page_idx    <= pnum;
        result.page_offset <= poff;
      end else begin
        result.page_idx    <= item_q.map_page;
        result.page_offset <= '0;
      end
      if (cmd.res_status == ST_HIT) begin
        result.paddr <= {frame_rd, poff};
      end else if (cmd.res_status == ST_REPLACED) begin
        result.paddr <= {vic_frame, poff};
      end else begin
        result.paddr <= '0;
      end
      if (cmd.res_status == ST_REPLACED) begin
        result.evict_frame <= vic_frame;
        result.writeback   <= wb;
        result.swap_slot   <= wb ? swap_cnt[SWAP_W-1:0] : '0;
      end else begin
        result.evict_frame <= '0;
        result.writeback   <= 1'b0;
        result.swap_slot   <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/demand_paging_translator_unit.sv =====
// A map or a fault found at the check ends after the check state; a hit goes on through the hit state.
// A miss adds a scan over the page table memory, one entry a cycle: LRU scans
// once and then picks the victim; FIFO scans again after each queue pop until a match.
// One item at a time; the next start is taken once busy falls.
// Reset (rst, synchronous): page table empty, queue empty, time zero, swap free.
// Results show for one cycle with done high; the receiver cannot stall.
`default_nettype none
module demand_paging_translator_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  dpt_pkg::in_item_t   in_item,
  output logic                done,
  output dpt_pkg::out_item_t  result,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  dpt_pkg::cfg_idx_t   cfg_index,
  input  wire [16:0]          cfg_data
);
  import dpt_pkg::*;

  dpt_cmd_t  cmd;
  dpt_stat_t stat;

  assign cfg_ready = 1'b1;

  dpt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  dpt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

endmodule
`default_nettype wire

// ===== design/dpt_checker.sv =====
`default_nettype none
module dpt_checker (
  input wire                clk,
  input wire                rst,
  input wire                start,
  input wire                busy,
  input wire                done,
  input dpt_pkg::out_item_t result
);
  import dpt_pkg::*;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("item finished without work");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item not started");

  a_phys_offset: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_HIT || result.status == ST_REPLACED))
      |-> (result.paddr[OFF_W-1:0] == result.page_offset))
    else $error("physical address offset mismatch");

  a_no_victim: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_REPLACED)
      |-> (result.evict_frame == '0 && !result.writeback))
    else $error("victim reported without replacement");

endmodule

bind demand_paging_translator_unit dpt_checker u_dpt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire
